// ===== sv/srop_pkg.sv =====
package srop_pkg;

    localparam int DEPTH_DEFAULT = 1024;

    localparam int TYPE_W  = 3;
    localparam int POS_W   = 11;
    localparam int VAL_W   = 32;
    localparam int SUM_W   = 42;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 11;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 56;

    localparam logic [TYPE_W-1:0] OP_INSERT  = 3'd0;
    localparam logic [TYPE_W-1:0] OP_DELETE  = 3'd1;
    localparam logic [TYPE_W-1:0] OP_ASSIGN  = 3'd2;
    localparam logic [TYPE_W-1:0] OP_REVERSE = 3'd3;
    localparam logic [TYPE_W-1:0] OP_SUM     = 3'd4;
    localparam logic [TYPE_W-1:0] OP_MAXSUM  = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== sv/sequence_range_ops_engine.sv =====
// sequence_range_ops_engine
// keeps an ordered sequence of signed 32-bit values (1-based, up to DEPTH long)
// in one single-port-write, single-port-read ram with a registered read
// input channel s_*: one request item per handshake (insert, delete, assign,
// reverse, range sum, max subarray sum)
// output channel m_*: exactly one result item per request, in request order
// steps from acceptance to result, one element per cycle in the run state:
//   insert   shift up from the end, then place the value
//   delete   shift down the elements behind the range
//   assign   write the value over the range, range sum adds up the range
//   reverse  read both ends of each pair, then write them back swapped
//   max sum  one pass over the sequence (running prefix, lowest prefix, best gap)
//   flagged requests go straight to the result
// so an item's work grows with the elements it touches, set by the single ram port
// s_tready is high while no request is in work; a new request is taken while
// the previous result still sits in the output register
// a stalled receiver holds the finished result in the engine until m_tready
// reset empties the sequence and the output register; ram contents are left
// as they are, only entries below the current length are ever used
module sequence_range_ops_engine
    import srop_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // req_type[3], position[11], count[11], value[32]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // sum_result[42], status[2], length_after[11]
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 2;
    localparam int PW = ((VAL_W + LW + 1) > (SUM_W + 1)) ? (VAL_W + LW + 1) : (SUM_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_FIN,
        S_REV_RA,
        S_REV_RB,
        S_REV_WA,
        S_REV_WB,
        S_DONE
    } state_t;

    state_t state_reg;

    // request fields
    logic [TYPE_W-1:0] in_type;
    logic [CW-1:0]     in_pos;
    logic [CW-1:0]     in_cnt;
    logic [VAL_W-1:0]  in_val;

    assign in_type = s_tdata[2:0];
    assign in_pos  = CW'(s_tdata[13:3]);
    assign in_cnt  = CW'(s_tdata[24:14]);
    assign in_val  = s_tdata[56:25];

    logic [TYPE_W-1:0] op_reg;
    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     cnt_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     ptr_reg;
    logic [LW-1:0]     left_reg;
    logic              pend_reg;
    logic [LW-1:0]     wpipe_reg;
    logic [LW-1:0]     rev_a_reg;
    logic [LW-1:0]     rev_b_reg;
    logic [VAL_W-1:0]  tmp_reg;
    logic [STAT_W-1:0] status_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] low_reg;
    logic signed [PW-1:0] best_reg;

    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    // ram port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    srop_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wpipe_reg[AW-1:0];
        mem_wdata = mem_rdata;
        mem_raddr = ptr_reg[AW-1:0];
        case (state_reg)
            S_RUN:
            begin
                if (op_reg == OP_ASSIGN)
                begin
                    mem_we    = (left_reg != '0);
                    mem_waddr = ptr_reg[AW-1:0];
                    mem_wdata = val_reg;
                end
                else if (op_reg == OP_INSERT || op_reg == OP_DELETE)
                begin
                    mem_we = pend_reg;
                end
            end
            S_FIN:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = val_reg;
            end
            S_REV_RA:
            begin
                mem_raddr = rev_a_reg[AW-1:0];
            end
            S_REV_RB:
            begin
                mem_raddr = rev_b_reg[AW-1:0];
            end
            S_REV_WA:
            begin
                mem_we    = 1'b1;
                mem_waddr = rev_a_reg[AW-1:0];
            end
            S_REV_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = rev_b_reg[AW-1:0];
                mem_wdata = tmp_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // range check against the current length
    logic [CW-1:0] len_ext;
    logic          range_ok;

    assign len_ext  = CW'(len_reg);
    assign range_ok = (in_pos != '0) && ((in_pos + in_cnt) <= (len_ext + CW'(1)));

    // running prefix for max sum
    logic signed [PW-1:0] rd_ext;
    logic signed [PW-1:0] prefix_next;
    logic signed [PW-1:0] gap;

    assign rd_ext      = PW'(signed'(mem_rdata));
    assign prefix_next = acc_reg + rd_ext;
    assign gap         = prefix_next - low_reg;

    // final sum, saturated to the result width
    logic signed [PW-1:0] sum_raw;
    logic [SUM_W-1:0]     sum_sat;

    localparam logic signed [PW-1:0] SUM_HI = PW'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SUM_LO = -SUM_HI - PW'(1);

    always_comb
    begin
        sum_raw = '0;
        if (status_reg == ST_OK && op_reg == OP_SUM)
        begin
            sum_raw = acc_reg;
        end
        else if (status_reg == ST_OK && op_reg == OP_MAXSUM)
        begin
            sum_raw = best_reg;
        end
        if (sum_raw > SUM_HI)
        begin
            sum_sat = SUM_HI[SUM_W-1:0];
        end
        else if (sum_raw < SUM_LO)
        begin
            sum_sat = SUM_LO[SUM_W-1:0];
        end
        else
        begin
            sum_sat = sum_raw[SUM_W-1:0];
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            left_reg      <= '0;
            status_reg    <= ST_OK;
            op_reg        <= OP_INSERT;
        end
        else
        begin
            // the done state loads the next result itself
            if (out_valid_reg && m_tready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg     <= in_type;
                        pos_reg    <= in_pos;
                        cnt_reg    <= in_cnt;
                        val_reg    <= in_val;
                        status_reg <= ST_OK;
                        pend_reg   <= 1'b0;
                        acc_reg    <= '0;
                        low_reg    <= '0;
                        best_reg   <= '0;
                        state_reg  <= S_DONE;
                        case (in_type)
                            OP_INSERT:
                            begin
                                if (in_pos > len_ext)
                                begin
                                    status_reg <= ST_RANGE;
                                end
                                else if (len_ext >= CW'(DEPTH))
                                begin
                                    status_reg <= ST_FULL;
                                end
                                else
                                begin
                                    ptr_reg   <= len_reg - LW'(1);
                                    left_reg  <= LW'(len_ext - in_pos);
                                    state_reg <= S_RUN;
                                end
                            end
                            OP_DELETE:
                            begin
                                if (!range_ok)
                                begin
                                    status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    ptr_reg   <= LW'(in_pos - CW'(1) + in_cnt);
                                    left_reg  <= LW'(len_ext + CW'(1) - in_pos - in_cnt);
                                    state_reg <= S_RUN;
                                end
                            end
                            OP_ASSIGN, OP_SUM:
                            begin
                                if (!range_ok)
                                begin
                                    status_reg <= ST_RANGE;
                                end
                                else
                                begin
                                    ptr_reg   <= LW'(in_pos - CW'(1));
                                    left_reg  <= LW'(in_cnt);
                                    state_reg <= S_RUN;
                                end
                            end
                            OP_REVERSE:
                            begin
                                if (!range_ok)
                                begin
                                    status_reg <= ST_RANGE;
                                end
                                else if (in_cnt > CW'(1))
                                begin
                                    rev_a_reg <= LW'(in_pos - CW'(1));
                                    rev_b_reg <= LW'(in_pos + in_cnt - CW'(2));
                                    state_reg <= S_REV_RA;
                                end
                            end
                            OP_MAXSUM:
                            begin
                                ptr_reg   <= '0;
                                left_reg  <= len_reg;
                                state_reg <= S_RUN;
                            end
                            default:
                            begin
                                status_reg <= ST_RANGE;
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    // issue one read per cycle, consume the one issued before
                    if (left_reg != '0)
                    begin
                        left_reg  <= left_reg - LW'(1);
                        pend_reg  <= (op_reg != OP_ASSIGN);
                        ptr_reg   <= (op_reg == OP_INSERT) ? ptr_reg - LW'(1) : ptr_reg + LW'(1);
                        wpipe_reg <= (op_reg == OP_INSERT) ? ptr_reg + LW'(1)
                                                           : ptr_reg - LW'(cnt_reg);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && op_reg == OP_SUM)
                    begin
                        acc_reg <= prefix_next;
                    end
                    if (pend_reg && op_reg == OP_MAXSUM)
                    begin
                        acc_reg <= prefix_next;
                        if (gap > best_reg)
                        begin
                            best_reg <= gap;
                        end
                        if (prefix_next < low_reg)
                        begin
                            low_reg <= prefix_next;
                        end
                    end
                    if (left_reg == '0 && !pend_reg)
                    begin
                        if (op_reg == OP_INSERT)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            if (op_reg == OP_DELETE)
                            begin
                                len_reg <= len_reg - LW'(cnt_reg);
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_FIN:
                begin
                    len_reg   <= len_reg + LW'(1);
                    state_reg <= S_DONE;
                end
                S_REV_RA:
                begin
                    state_reg <= S_REV_RB;
                end
                S_REV_RB:
                begin
                    tmp_reg   <= mem_rdata;
                    state_reg <= S_REV_WA;
                end
                S_REV_WA:
                begin
                    state_reg <= S_REV_WB;
                end
                S_REV_WB:
                begin
                    rev_a_reg <= rev_a_reg + LW'(1);
                    rev_b_reg <= rev_b_reg - LW'(1);
                    if ((rev_a_reg + LW'(2)) < rev_b_reg)
                    begin
                        state_reg <= S_REV_RA;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {1'b0, LEN_W'(len_reg), status_reg, sum_sat};
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    // the sequence never outgrows the store
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(DEPTH))
        else $error("sequence length above depth");

    // a result never carries an undefined status code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[43:42] == ST_OK || m_tdata[43:42] == ST_RANGE
                      || m_tdata[43:42] == ST_FULL))
        else $error("bad status on result");

    // an accepted request drops s_tready in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous still in work");

    // the length only changes while a modifying request finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(len_reg))
        else $error("length changed while idle");
`endif

endmodule

// ===== sv/srop_mem.sv =====
module srop_mem
    import srop_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/sv/sequence_range_ops_engine_test.sv =====
module sequence_range_ops_engine_test;
    import srop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = DEPTH_DEFAULT;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [POS_W-1:0]  position;
        logic [POS_W-1:0]  count;
        logic [VAL_W-1:0]  value;
    } request_t;

    typedef struct packed {
        logic [SUM_W-1:0]  sum_result;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length_after;
    } result_t;

    logic             clk;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;   // req_type, position, count, value, zero fill
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;   // sum_result, status, length_after

    sequence_range_ops_engine #(.DEPTH(DEPTH)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow copy of the sequence held by the engine
    int signed shadow_seq[$];
    // length tracked at generation time so stimulus stays inside bounds
    int        gen_len;

    request_t  pending_reqs[$];
    result_t   expected_results[$];
    int        mismatch_count;
    int        results_seen;
    bit        hold_off;

    always #6 clk = ~clk;

    // pack fields from bit 0 up: req_type lowest, value highest
    function automatic logic [IN_W-1:0] pack_request(request_t r);
        logic [IN_W-1:0] d;
        d = '0;
        d[TYPE_W-1:0] = r.req_type;
        d[TYPE_W +: POS_W] = r.position;
        d[TYPE_W+POS_W +: POS_W] = r.count;
        d[TYPE_W+2*POS_W +: VAL_W] = r.value;
        return d;
    endfunction

    function automatic result_t unpack_result(logic [OUT_W-1:0] d);
        result_t r;
        r.sum_result   = d[SUM_W-1:0];
        r.status       = d[SUM_W +: STAT_W];
        r.length_after = d[SUM_W+STAT_W +: LEN_W];
        return r;
    endfunction

    // apply one accepted request to the shadow sequence and compute its result
    function automatic result_t apply_request(request_t r);
        result_t     res;
        int          len, p, c, lo, a, b;
        int signed   v, t;
        longint      acc, run, low_run, best;
        bit          in_range;
        len = shadow_seq.size();
        p = int'(r.position);
        c = int'(r.count);
        v = r.value;
        acc = 0;
        res.status = ST_OK;
        in_range = (p >= 1) && (p + c <= len + 1);
        lo = p - 1;
        case (r.req_type)
            OP_INSERT:
            begin
                if (p > len) res.status = ST_RANGE;
                else if (len >= DEPTH) res.status = ST_FULL;
                else shadow_seq.insert(p, v);
            end
            OP_DELETE:
            begin
                if (!in_range) res.status = ST_RANGE;
                else for (int i = 0; i < c; i++) shadow_seq.delete(lo);
            end
            OP_ASSIGN:
            begin
                if (!in_range) res.status = ST_RANGE;
                else for (int i = 0; i < c; i++) shadow_seq[lo + i] = v;
            end
            OP_REVERSE:
            begin
                if (!in_range) res.status = ST_RANGE;
                else
                begin
                    a = lo;
                    b = lo + c - 1;
                    while (a < b)
                    begin
                        t = shadow_seq[a];
                        shadow_seq[a] = shadow_seq[b];
                        shadow_seq[b] = t;
                        a++;
                        b--;
                    end
                end
            end
            OP_SUM:
            begin
                if (!in_range) res.status = ST_RANGE;
                else for (int i = 0; i < c; i++) acc += shadow_seq[lo + i];
            end
            OP_MAXSUM:
            begin
                // kadane via lowest running prefix, empty run allowed
                run = 0;
                low_run = 0;
                best = 0;
                foreach (shadow_seq[i])
                begin
                    run += shadow_seq[i];
                    if (run - low_run > best) best = run - low_run;
                    if (run < low_run) low_run = run;
                end
                acc = best;
            end
            default: res.status = ST_RANGE;
        endcase
        // 42-bit sums cannot overflow at this depth, no saturation needed
        res.sum_result = acc[SUM_W-1:0];
        res.length_after = LEN_W'(shadow_seq.size());
        return res;
    endfunction

    // queue a request and keep the generation-time length in step
    task automatic push_req(logic [TYPE_W-1:0] op, int p, int c, int signed v);
        request_t r;
        r.req_type = op;
        r.position = POS_W'(p);
        r.count = POS_W'(c);
        r.value = v;
        pending_reqs.push_back(r);
        if (op == OP_INSERT && p <= gen_len && gen_len < DEPTH) gen_len++;
        if (op == OP_DELETE && p >= 1 && p + c <= gen_len + 1) gen_len -= c;
    endtask

    // random value biased toward the extremes
    function automatic int signed pick_value();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // random well-formed range inside the current length, mostly short
    task automatic pick_range(output int p, output int c);
        p = $urandom_range(1, gen_len + 1);
        c = $urandom_range(0, gen_len + 1 - p);
        if (c > 40 && $urandom_range(0, 7) != 0) c = $urandom_range(0, 40);
    endtask

    task automatic add_random_item();
        int p, c, k;
        k = $urandom_range(0, 99);
        if (k < 8)
        begin
            // noise: any field value, including unknown codes and bad ranges
            push_req(TYPE_W'($urandom_range(0, 7)), $urandom_range(0, 2047),
                     $urandom_range(0, 2047), pick_value());
        end
        else if (k < 40 || gen_len < 4)
            push_req(OP_INSERT, $urandom_range(0, gen_len), 0, pick_value());
        else
        begin
            pick_range(p, c);
            case ($urandom_range(0, 4))
                0: push_req(OP_DELETE, p, (c > 4) ? $urandom_range(0, 4) : c, 0);
                1: push_req(OP_ASSIGN, p, c, pick_value());
                2: push_req(OP_REVERSE, p, c, pick_value());
                3: push_req(OP_SUM, p, c, 0);
                default: push_req(OP_MAXSUM, 0, $urandom_range(0, 2047), 0);
            endcase
        end
    endtask

    // sender: bursts of random length with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_request(pending_reqs.pop_front()));
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pack_request(pending_reqs[0]);
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else burst_left <= burst_left - 1;
                end
                else s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stalls on its own pattern, plus a long hold-off phase
    int stall_phase;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_off) m_tready <= 1'b0;
            else if (stall_phase[9:8] == 2'd3) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            result_t got, want;
            got = unpack_result(m_tdata);
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result item: sum=%0d status=%0d len=%0d",
                             $signed(got.sum_result), got.status, got.length_after);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: exp sum=%0d st=%0d len=%0d got sum=%0d st=%0d len=%0d",
                                 $signed(want.sum_result), want.status, want.length_after,
                                 $signed(got.sum_result), got.status, got.length_after);
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering items
    initial
    begin
        hold_off = 1'b0;
        wait (results_seen > 60);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #50_000_000;
        $display("sequence_range_ops_engine_test: FAIL");
        $finish;
    end

    initial
    begin
        int drain;
        clk = 1'b0;
        rst_n = 1'b0;
        mismatch_count = 0;
        results_seen = 0;
        gen_len = 0;

        // directed: empty-sequence cases, unknown codes, extremes
        push_req(OP_MAXSUM, 0, 0, 0);
        push_req(OP_SUM, 1, 0, 0);
        push_req(OP_DELETE, 1, 1, 0);
        push_req(OP_INSERT, 1, 0, 5);
        push_req(OP_INSERT, 0, 0, 32'sh7fffffff);
        push_req(OP_INSERT, 1, 0, 32'sh80000000);
        push_req(OP_INSERT, 2, 0, -3);
        push_req(OP_INSERT, 0, 0, 7);
        push_req(OP_SUM, 1, 4, 0);
        push_req(OP_SUM, 0, 1, 0);
        push_req(OP_SUM, 5, 0, 0);
        push_req(OP_SUM, 3, 3, 0);
        push_req(OP_REVERSE, 1, 4, 0);
        push_req(OP_REVERSE, 2, 1, 0);
        push_req(OP_MAXSUM, 0, 0, 0);
        push_req(OP_ASSIGN, 2, 2, -1);
        push_req(OP_ASSIGN, 5, 0, 1);
        push_req(3'd6, 1, 1, 0);
        push_req(3'd7, 11'h7ff, 11'h7ff, 32'shffffffff);
        push_req(OP_DELETE, 2, 0, 0);
        push_req(OP_DELETE, 3, 2, 0);
        push_req(OP_INSERT, 11'h7ff, 0, 1);
        push_req(OP_MAXSUM, 0, 0, 0);

        // random work, then whole-sequence requests, then more random work
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 480; i++) add_random_item();
        push_req(OP_INSERT, 0, 0, 1);
        push_req(OP_MAXSUM, 0, 0, 0);
        push_req(OP_SUM, 1, gen_len, 0);
        push_req(OP_REVERSE, 1, gen_len, 0);
        if (gen_len > 5) push_req(OP_DELETE, 1, gen_len - 5, 0);
        for (int i = 0; i < 80; i++) add_random_item();

        wait (pending_reqs.size() == 0);
        wait (expected_results.size() == 0);
        drain = 0;
        while (drain < DEPTH + 20)
        begin
            @(posedge clk);
            drain++;
        end
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("sequence_range_ops_engine_test: PASS");
        else
            $display("sequence_range_ops_engine_test: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/srop_pkg.sv
sv/srop_mem.sv
sv/sequence_range_ops_engine.sv
tb/sv/sequence_range_ops_engine_test.sv
